>>> rtl/core/text_console_char_engine_defines.svh
// assertion macros shared by the console engine
`ifndef TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH

// same-cycle implication
`define TCCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tcce_pkg.sv
package tcce_pkg;

	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;
	localparam int TAB_DEF  = 8;

	localparam int CELL_W     = 16;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;
	localparam int POS_OUT_W  = 11;
	localparam int ROW_IN_W   = 5;
	localparam int COL_IN_W   = 7;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [7:0] ATTR_RESET = 8'h0F;
	localparam logic       KEEP_RESET = 1'b1;
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, BLANK_CHAR};

	// control bytes
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic REG_TEXT_ATTR = 1'b0;
	localparam logic REG_KEEP_TOP  = 1'b1;

	typedef enum logic [1:0] {
		CUR_HOLD     = 2'd0,
		CUR_BYTE     = 2'd1,
		CUR_HOME     = 2'd2,
		CUR_LAST_ROW = 2'd3
	} cur_op_t;

	typedef struct packed {
		cur_op_t    op;
		logic [7:0] ch;
	} cur_cmd_t;

endpackage

>>> rtl/core/tcce_cursor.sv
module tcce_cursor #(
	parameter int SCREEN_COLS = tcce_pkg::COLS_DEF,
	parameter int SCREEN_ROWS = tcce_pkg::ROWS_DEF,
	parameter int TAB_STOP    = tcce_pkg::TAB_DEF,
	localparam int RW = $clog2(SCREEN_ROWS + 1),
	localparam int CW = $clog2(SCREEN_COLS),
	localparam int PW = $clog2(SCREEN_ROWS * SCREEN_COLS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcce_pkg::cur_cmd_t cmd,
	output logic [RW-1:0]     row,
	output logic [CW-1:0]     col,
	output logic [PW-1:0]     pos
);
	import tcce_pkg::*;

	localparam int NW = $clog2(SCREEN_COLS + TAB_STOP);
	localparam int MW = $clog2(TAB_STOP);

	logic [RW-1:0] row_q, row_d, row_inc;
	logic [CW-1:0] col_q, col_d;
	logic [MW-1:0] mod_q, mod_d;
	logic [NW-1:0] ncol;

	// row + 1, saturating at the pending-scroll row
	assign row_inc = (row_q == RW'(SCREEN_ROWS)) ? row_q : row_q + RW'(1);

	always_comb begin
		row_d = row_q;
		col_d = col_q;
		mod_d = mod_q;
		ncol  = NW'(col_q) + NW'(1);
		case (cmd.op)
			CUR_HOME: begin
				row_d = '0;
				col_d = '0;
				mod_d = '0;
			end
			CUR_LAST_ROW: begin
				row_d = RW'(SCREEN_ROWS - 1);
				col_d = '0;
				mod_d = '0;
			end
			CUR_BYTE: begin
				case (cmd.ch)
					CH_BS: begin
						if (col_q != '0) begin
							col_d = col_q - CW'(1);
							mod_d = (mod_q == '0) ? MW'(TAB_STOP - 1) : mod_q - MW'(1);
						end
					end
					CH_TAB: begin
						ncol = NW'(col_q) - NW'(mod_q) + NW'(TAB_STOP);
						mod_d = '0;
						if (ncol >= NW'(SCREEN_COLS)) begin
							row_d = row_inc;
							col_d = '0;
						end else begin
							col_d = CW'(ncol);
						end
					end
					CH_LF: begin
						row_d = row_inc;
						col_d = '0;
						mod_d = '0;
					end
					CH_CR: begin
						col_d = '0;
						mod_d = '0;
					end
					CH_FF: begin
						row_d = row_q;
					end
					default: begin
						if (ncol >= NW'(SCREEN_COLS)) begin
							row_d = row_inc;
							col_d = '0;
							mod_d = '0;
						end else begin
							col_d = CW'(ncol);
							mod_d = (mod_q == MW'(TAB_STOP - 1)) ? '0 : mod_q + MW'(1);
						end
					end
				endcase
			end
			default: begin
				row_d = row_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			mod_q <= '0;
		end else begin
			row_q <= row_d;
			col_q <= col_d;
			mod_q <= mod_d;
		end
	end

	assign row = row_q;
	assign col = col_q;
	assign pos = PW'(PW'(row_q) * PW'(SCREEN_COLS)) + PW'(col_q);

endmodule

>>> rtl/core/text_console_char_engine.sv
// Text console engine: a screen of SCREEN_ROWS x SCREEN_COLS cells (attribute high
// byte, character low byte) in one synchronous RAM, plus a cursor.
// Input channel (in_valid/in_stall): cmd 0 puts char_byte at the cursor, cmd 1 reads
// the cell at read_row/read_col. Every word gives one result word on the output
// channel (out_valid/out_stall) with the cell read (0 for a put) and the cursor.
// A put that finds a scroll pending first copies each row up through the RAM, one
// cell a cycle over its single read and write port, then blanks the bottom row;
// when keep_top_line is set, row 0 is held out of the copy.
// One word is worked at a time; the next is taken once the result is in the output
// register, even while that register is stalled, and a result waits there until
// out_stall drops. A stall holds only the loading of a result; the next word is still worked.
// After reset the RAM is swept to space/attribute 0x0F, one cell a cycle, while
// in_stall stays high; APB writes are taken throughout.
// text_attr at 0x0, keep_top_line at 0x4; write configuration only while idle.
`include "text_console_char_engine_defines.svh"

module text_console_char_engine #(
	parameter int SCREEN_COLS = tcce_pkg::COLS_DEF,
	parameter int SCREEN_ROWS = tcce_pkg::ROWS_DEF,
	parameter int TAB_STOP    = tcce_pkg::TAB_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcce_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tcce_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tcce_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [7:0]                      char_byte,
	input  logic [tcce_pkg::ROW_IN_W-1:0]   read_row,
	input  logic [tcce_pkg::COL_IN_W-1:0]   read_col,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcce_pkg::CELL_W-1:0]     cell_data,
	output logic [tcce_pkg::ROW_OUT_W-1:0]  cursor_row,
	output logic [tcce_pkg::COL_OUT_W-1:0]  cursor_col,
	output logic [tcce_pkg::POS_OUT_W-1:0]  cursor_pos
);
	import tcce_pkg::*;

	localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(SCREEN_ROWS + 1);
	localparam int CW    = $clog2(SCREEN_COLS);
	localparam int PW    = $clog2(CELLS + 1);
	localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_ROW_BASE = AW'((SCREEN_ROWS - 1) * SCREEN_COLS);

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_SCROLL = 6'b000100,
		S_PUT    = 6'b001000,
		S_CLEAR  = 6'b010000,
		S_RESULT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [AW-1:0] sweep_q, sweep_d;

	logic [7:0] attr_q;
	logic       keep_q;
	logic       cfg_wr;

	logic       cmd_q;
	logic [7:0] char_q;
	logic       rd_ok_q;

	logic              in_acc;
	logic              read_ok;
	logic [AW-1:0]     read_addr;
	logic              load_out;

	// ram ports
	logic [CELL_W-1:0] screen_q [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_v_d, wr_mem_d;
	logic [AW-1:0]     wr_addr_d;
	logic [CELL_W-1:0] wr_data_d;
	logic              wr_v_s1, wr_mem_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic [CELL_W-1:0] wr_data_s1;

	cur_cmd_t      cur_cmd;
	logic [RW-1:0] cur_row;
	logic [CW-1:0] cur_col;
	logic [PW-1:0] cur_pos;

	logic                 out_valid_q;
	logic [CELL_W-1:0]    cell_q;
	logic [ROW_OUT_W-1:0] row_out_q;
	logic [COL_OUT_W-1:0] col_out_q;
	logic [POS_OUT_W-1:0] pos_out_q;

	tcce_cursor #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS),
		.TAB_STOP   (TAB_STOP)
	) u_cursor (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cur_cmd),
		.row   (cur_row),
		.col   (cur_col),
		.pos   (cur_pos)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_KEEP_TOP) ? APB_DATA_W'(keep_q) : APB_DATA_W'(attr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
			keep_q <= KEEP_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_TEXT_ATTR) begin
				attr_q <= pwdata[7:0];
			end else begin
				keep_q <= pwdata[0];
			end
		end
	end

	// a pending ram write holds off the next word so a read never races it
	assign in_stall  = (state_q != S_IDLE) || wr_v_s1;
	assign in_acc    = in_valid && !in_stall;
	assign read_ok   = (int'(read_row) < SCREEN_ROWS) && (int'(read_col) < SCREEN_COLS);
	assign read_addr = read_ok ? AW'(AW'(read_row) * AW'(SCREEN_COLS)) + AW'(read_col) : '0;

	always_comb begin
		state_d   = state_q;
		sweep_d   = sweep_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_v_d    = 1'b0;
		wr_mem_d  = 1'b0;
		wr_addr_d = sweep_q;
		wr_data_d = {attr_q, BLANK_CHAR};
		cur_cmd   = '{op: CUR_HOLD, ch: char_q};
		load_out  = 1'b0;
		case (state_q)
			S_INIT: begin
				wr_v_d    = 1'b1;
				wr_data_d = RESET_CELL;
				sweep_d   = sweep_q + AW'(1);
				if (sweep_q == LAST_CELL) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_READ) begin
						rd_en   = read_ok;
						rd_addr = read_addr;
						state_d = S_RESULT;
					end else if (cur_row == RW'(SCREEN_ROWS)) begin
						sweep_d = keep_q ? AW'(SCREEN_COLS) : '0;
						state_d = S_SCROLL;
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_SCROLL: begin
				// read the cell one row below, write it back here in the following cycle
				wr_v_d = 1'b1;
				if (sweep_q < LAST_ROW_BASE) begin
					rd_en    = 1'b1;
					rd_addr  = sweep_q + AW'(SCREEN_COLS);
					wr_mem_d = 1'b1;
				end
				sweep_d = sweep_q + AW'(1);
				if (sweep_q == LAST_CELL) begin
					cur_cmd.op = CUR_LAST_ROW;
					state_d    = S_PUT;
				end
			end
			S_PUT: begin
				if (char_q == CH_FF) begin
					sweep_d = '0;
					state_d = S_CLEAR;
				end else begin
					cur_cmd.op = CUR_BYTE;
					if (!(char_q inside {CH_BS, CH_TAB, CH_LF, CH_CR})) begin
						wr_v_d    = 1'b1;
						wr_addr_d = AW'(cur_pos);
						wr_data_d = {attr_q, char_q};
					end
					state_d = S_RESULT;
				end
			end
			S_CLEAR: begin
				wr_v_d  = 1'b1;
				sweep_d = sweep_q + AW'(1);
				if (sweep_q == LAST_CELL) begin
					cur_cmd.op = CUR_HOME;
					state_d    = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= '0;
			wr_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			wr_v_s1 <= wr_v_d;
		end
	end

	always_ff @(posedge clk) begin
		wr_mem_s1  <= wr_mem_d;
		wr_addr_s1 <= wr_addr_d;
		wr_data_s1 <= wr_data_d;
		if (in_acc) begin
			cmd_q   <= cmd;
			char_q  <= char_byte;
			rd_ok_q <= read_ok;
		end
	end

	// screen ram, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_v_s1) begin
			screen_q[wr_addr_s1] <= wr_mem_s1 ? rdata_q : wr_data_s1;
		end
		if (rd_en) begin
			rdata_q <= screen_q[rd_addr];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cell_q    <= (cmd_q == CMD_READ && rd_ok_q) ? rdata_q : '0;
			row_out_q <= ROW_OUT_W'(cur_row);
			col_out_q <= COL_OUT_W'(cur_col);
			pos_out_q <= POS_OUT_W'(cur_pos);
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_data  = cell_q;
	assign cursor_row = row_out_q;
	assign cursor_col = col_out_q;
	assign cursor_pos = pos_out_q;

	`TCCE_ASSERT_NOW(a_copy_no_overlap, clk, arst_n, rd_en && wr_v_s1, rd_addr != wr_addr_s1,
		"ram read and write hit the same cell")
	`TCCE_ASSERT_NOW(a_put_row_on_screen, clk, arst_n, state_q == S_PUT,
		cur_row < RW'(SCREEN_ROWS), "byte handled with a scroll still pending")
	`TCCE_ASSERT_NXT(a_scroll_ends_last_row, clk, arst_n,
		state_q == S_SCROLL && sweep_q == LAST_CELL,
		cur_row == RW'(SCREEN_ROWS - 1) && cur_col == '0, "scroll left cursor off bottom row")

endmodule
